[src/bss_pkg.sv]
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants of the beat-reactive sweep unit: controller
// states, datapath commands, filter coefficients and fixed-point helpers.
// ----------------------------------------------------------------------------
package bss_pkg;

    // Fixed-point limits of the 40-bit filter values.
    localparam int COEF_BITS = 22;
    localparam logic signed [50:0] MAX40 = 51'sd549755813887;
    localparam logic signed [50:0] MIN40 = -51'sd549755813888;

    // Q22 filter coefficients.
    localparam logic signed [23:0] C_BASS_A = -24'sd3338691;
    localparam logic signed [23:0] C_BASS_B = 24'sd7509115;
    localparam logic signed [23:0] C_ENV    = 24'sd4141925;
    localparam logic signed [23:0] C_BEAT_A = -24'sd3007258;
    localparam logic signed [23:0] C_BEAT_B = 24'sd6062302;

    // Input scalings 2^22/160 and 2^22/7.015, rounded.
    localparam logic signed [23:0] K_ENV_IN =
        24'(((64'd1 << COEF_BITS) + 64'd80) / 64'd160);
    localparam logic signed [23:0] K_BEAT_IN =
        24'(((64'd1 << COEF_BITS) * 64'd1000 + 64'd3507) / 64'd7015);

    // floor(v / 50) == (v * 1311) >> 16 for every 12-bit v.
    localparam logic [10:0] Y_RECIP = 11'd1311;
    localparam int          Y_SHIFT = 16;

    localparam logic [13:0] CLAMP_TOP = 14'd4090;
    localparam logic [7:0]  JITTER_BIAS = 8'd25;

    // Reset values of the registers and of the state.
    localparam logic [9:0]  RST_SLEW_LIMIT   = 10'd130;
    localparam logic [7:0]  RST_SWEEP_MAX    = 8'd222;
    localparam logic [11:0] RST_DC_OFFSET    = 12'd1430;
    localparam logic [9:0]  RST_BEAT_RATIO   = 10'd145;
    localparam logic [9:0]  RST_BEAT_MARGIN  = 10'd45;
    localparam logic [15:0] RST_BLANK_TICKS  = 16'd3;
    localparam logic [15:0] RST_ACTIVE_TICKS = 16'd100;
    localparam logic [15:0] RST_REARM_TICKS  = 16'd2000;
    localparam logic [11:0] RST_SLEW_PREV    = 12'd2048;
    localparam logic [7:0]  RST_WINDOW_STOP  = 8'd222;

    typedef enum logic [2:0] {
        REG_SLEW_LIMIT   = 3'd0,
        REG_SWEEP_MAX    = 3'd1,
        REG_DC_OFFSET    = 3'd2,
        REG_BEAT_RATIO   = 3'd3,
        REG_BEAT_MARGIN  = 3'd4,
        REG_BLANK_TICKS  = 3'd5,
        REG_ACTIVE_TICKS = 3'd6,
        REG_REARM_TICKS  = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_BLANK1 = 2'd1,
        PH_ACTIVE = 2'd2,
        PH_BLANK2 = 2'd3
    } hold_phase_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_XB_LO, S_XB_HI, S_XB_POST,
        S_BA_LO, S_BA_HI, S_BA_POST,
        S_BB_LO, S_BB_HI, S_BB_POST,
        S_ABS,
        S_EV_LO, S_EV_HI, S_EV_POST,
        S_EF_LO, S_EF_HI, S_EF_POST,
        S_KB_LO, S_KB_HI, S_KB_POST,
        S_TA_LO, S_TA_HI, S_TA_POST,
        S_TB_LO, S_TB_HI, S_TB_POST,
        S_SUM,
        S_JR_LO, S_JR_HI, S_JR_POST,
        S_JD_LO, S_JD_HI, S_JD_POST,
        S_FINISH
    } ctrl_state_t;

    // Operand pair of the shared multiplier.
    typedef enum logic [3:0] {
        SRC_XB, SRC_BA, SRC_BB, SRC_EV, SRC_EF,
        SRC_KB, SRC_TA, SRC_TB, SRC_JR, SRC_JD
    } mul_src_t;

    // Register update of a step, mostly one that follows a product.
    typedef enum logic [3:0] {
        P_NONE, P_CAPTURE, P_XB, P_ACC, P_BASS_Y, P_ABS, P_ENV_XE,
        P_ENV_E, P_BEAT_X, P_BEAT_Y, P_SUM, P_JR, P_JD, P_FINISH
    } post_op_t;

    typedef struct packed {
        mul_src_t src;
        logic     mul_lo;
        logic     mul_hi;
        post_op_t post;
    } dp_cmd_t;

    typedef struct packed {
        logic decim_hit;
        logic sum_last;
    } dp_status_t;

    function automatic logic signed [39:0] sat40(input logic signed [50:0] v);
        logic signed [39:0] r;
        if (v > MAX40)
            r = MAX40[39:0];
        else if (v < MIN40)
            r = MIN40[39:0];
        else
            r = v[39:0];
        return r;
    endfunction

    // Shift right by 22 with rounding half toward plus infinity.
    function automatic logic signed [49:0] round22(input logic signed [71:0] p);
        logic signed [71:0] t;
        t = p + 72'sd2097152;
        return t[71:22];
    endfunction

    function automatic logic signed [47:0] ext48(input logic signed [39:0] v);
        return {{8{v[39]}}, v};
    endfunction

    function automatic logic signed [50:0] ext51(input logic signed [47:0] v);
        return {{3{v[47]}}, v};
    endfunction

endpackage

[src/bss_ctrl.sv]
// ----------------------------------------------------------------------------
// bss_ctrl
// Sequencer of the sweep unit. Steps the datapath through the filter
// products of one tick and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module bss_ctrl
    import bss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    // The result register can take a new beat when it is empty or being taken.
    assign out_free  = !(out_valid_reg && out_stall);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_XB_LO;
            S_XB_LO:   state_next = S_XB_HI;
            S_XB_HI:   state_next = S_XB_POST;
            S_XB_POST: state_next = S_BA_LO;
            S_BA_LO:   state_next = S_BA_HI;
            S_BA_HI:   state_next = S_BA_POST;
            S_BA_POST: state_next = S_BB_LO;
            S_BB_LO:   state_next = S_BB_HI;
            S_BB_HI:   state_next = S_BB_POST;
            S_BB_POST: state_next = S_ABS;
            S_ABS:     state_next = S_EV_LO;
            S_EV_LO:   state_next = S_EV_HI;
            S_EV_HI:   state_next = S_EV_POST;
            S_EV_POST: state_next = S_EF_LO;
            S_EF_LO:   state_next = S_EF_HI;
            S_EF_HI:   state_next = S_EF_POST;
            S_EF_POST: state_next = status.decim_hit ? S_KB_LO : S_FINISH;
            S_KB_LO:   state_next = S_KB_HI;
            S_KB_HI:   state_next = S_KB_POST;
            S_KB_POST: state_next = S_TA_LO;
            S_TA_LO:   state_next = S_TA_HI;
            S_TA_HI:   state_next = S_TA_POST;
            S_TA_POST: state_next = S_TB_LO;
            S_TB_LO:   state_next = S_TB_HI;
            S_TB_HI:   state_next = S_TB_POST;
            S_TB_POST: state_next = S_SUM;
            S_SUM:     if (status.sum_last) state_next = S_JR_LO;
            S_JR_LO:   state_next = S_JR_HI;
            S_JR_HI:   state_next = S_JR_POST;
            S_JR_POST: state_next = S_JD_LO;
            S_JD_LO:   state_next = S_JD_HI;
            S_JD_HI:   state_next = S_JD_POST;
            S_JD_POST: state_next = S_FINISH;
            S_FINISH:  if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.src    = SRC_XB;
        cmd.mul_lo = 1'b0;
        cmd.mul_hi = 1'b0;
        cmd.post   = P_NONE;
        unique case (state_reg)
            S_IDLE:    cmd.post = in_valid ? P_CAPTURE : P_NONE;
            S_XB_LO:   begin cmd.src = SRC_XB; cmd.mul_lo = 1'b1; end
            S_XB_HI:   begin cmd.src = SRC_XB; cmd.mul_hi = 1'b1; end
            S_XB_POST: cmd.post = P_XB;
            S_BA_LO:   begin cmd.src = SRC_BA; cmd.mul_lo = 1'b1; end
            S_BA_HI:   begin cmd.src = SRC_BA; cmd.mul_hi = 1'b1; end
            S_BA_POST: cmd.post = P_ACC;
            S_BB_LO:   begin cmd.src = SRC_BB; cmd.mul_lo = 1'b1; end
            S_BB_HI:   begin cmd.src = SRC_BB; cmd.mul_hi = 1'b1; end
            S_BB_POST: cmd.post = P_BASS_Y;
            S_ABS:     cmd.post = P_ABS;
            S_EV_LO:   begin cmd.src = SRC_EV; cmd.mul_lo = 1'b1; end
            S_EV_HI:   begin cmd.src = SRC_EV; cmd.mul_hi = 1'b1; end
            S_EV_POST: cmd.post = P_ENV_XE;
            S_EF_LO:   begin cmd.src = SRC_EF; cmd.mul_lo = 1'b1; end
            S_EF_HI:   begin cmd.src = SRC_EF; cmd.mul_hi = 1'b1; end
            S_EF_POST: cmd.post = P_ENV_E;
            S_KB_LO:   begin cmd.src = SRC_KB; cmd.mul_lo = 1'b1; end
            S_KB_HI:   begin cmd.src = SRC_KB; cmd.mul_hi = 1'b1; end
            S_KB_POST: cmd.post = P_BEAT_X;
            S_TA_LO:   begin cmd.src = SRC_TA; cmd.mul_lo = 1'b1; end
            S_TA_HI:   begin cmd.src = SRC_TA; cmd.mul_hi = 1'b1; end
            S_TA_POST: cmd.post = P_ACC;
            S_TB_LO:   begin cmd.src = SRC_TB; cmd.mul_lo = 1'b1; end
            S_TB_HI:   begin cmd.src = SRC_TB; cmd.mul_hi = 1'b1; end
            S_TB_POST: cmd.post = P_BEAT_Y;
            S_SUM:     cmd.post = P_SUM;
            S_JR_LO:   begin cmd.src = SRC_JR; cmd.mul_lo = 1'b1; end
            S_JR_HI:   begin cmd.src = SRC_JR; cmd.mul_hi = 1'b1; end
            S_JR_POST: cmd.post = P_JR;
            S_JD_LO:   begin cmd.src = SRC_JD; cmd.mul_lo = 1'b1; end
            S_JD_HI:   begin cmd.src = SRC_JD; cmd.mul_hi = 1'b1; end
            S_JD_POST: cmd.post = P_JD;
            S_FINISH:  cmd.post = out_free ? P_FINISH : P_NONE;
            default:   cmd.post = P_NONE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == S_FINISH && out_free)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_finish_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && out_valid_reg && out_stall |=> state_reg == S_FINISH)
        else $error("finish step left while the result register was blocked");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post == P_FINISH |=> out_valid_reg && state_reg == S_IDLE)
        else $error("finished beat did not reach the result register");

    a_sum_loops: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM && !status.sum_last |=> state_reg == S_SUM)
        else $error("history sum stopped early");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_XB_LO)
        else $error("accepted beat did not start the filter sequence");

endmodule

[src/bss_datapath.sv]
// ----------------------------------------------------------------------------
// bss_datapath
// Filters, beat decision, hold machine, slew limiter and sweep of the unit.
// One shared multiplier forms every product, low half first, then high half.
// ----------------------------------------------------------------------------
module bss_datapath
    import bss_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10,
    parameter int DECIMATION    = 200,
    parameter int FRAC_BITS     = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [11:0] adc_sample,
    input  logic [5:0]  jitter_draw,
    input  logic [6:0]  start_draw,
    input  logic [6:0]  stop_draw,
    output logic [7:0]  dac_x,
    output logic [7:0]  dac_y,
    output logic        beam_on,
    output logic        beat_seen,
    output logic [1:0]  beat_phase
);

    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam logic signed [47:0] K_BASS_IN =
        48'(((64'd1 << (FRAC_BITS + COEF_BITS)) * 64'd10 + 64'd45) / 64'd91);

    // Configuration.
    logic [9:0]  slew_limit_reg;
    logic [7:0]  sweep_max_reg;
    logic [11:0] dc_offset_reg;
    logic [9:0]  beat_ratio_reg;
    logic [9:0]  beat_margin_reg;
    logic [15:0] blank_ticks_reg;
    logic [15:0] active_ticks_reg;
    logic [15:0] rearm_ticks_reg;

    // Captured beat.
    logic [11:0] adc_reg;
    logic [5:0]  jdraw_reg;
    logic [6:0]  sdraw_reg;
    logic [6:0]  pdraw_reg;

    // Filter state.
    logic signed [39:0] bass_hist_reg [4];
    logic signed [39:0] env_hist_reg [2];
    logic signed [39:0] beatf_hist_reg [4];
    logic signed [39:0] judge_window_reg [HISTORY_DEPTH];
    logic [7:0]         decim_count_reg;

    // Working registers.
    logic signed [47:0] acc_reg;
    logic signed [39:0] xin_reg;
    logic signed [39:0] val_reg;
    logic signed [47:0] sum_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic signed [63:0] lhs_reg;
    logic               beat_reg;
    logic signed [48:0] plo_reg;
    logic signed [71:0] prod_reg;

    // Output side state.
    logic [11:0]  c_reg;
    logic [11:0]  slew_prev_reg;
    logic [6:0]   ydiv_reg;
    logic [7:0]   sweep_pos_reg;
    logic         sweep_rising_reg;
    hold_phase_t  phase_reg;
    logic [15:0]  hold_count_reg;
    logic [7:0]   jitter_reg;
    logic [7:0]   window_start_reg;
    logic [7:0]   window_stop_reg;
    logic [7:0]   dac_x_reg;
    logic [7:0]   dac_y_reg;
    logic         beam_on_reg;
    logic         beat_seen_reg;
    logic [1:0]   beat_phase_reg;

    logic signed [47:0] mul_a;
    logic signed [23:0] mul_b;
    logic signed [48:0] plo_next;
    logic signed [47:0] phi;
    logic signed [71:0] prod_next;
    logic signed [49:0] rnd;
    logic signed [39:0] rnd_sat;
    logic signed [39:0] acc_sat;
    logic signed [12:0] s_val;

    logic signed [13:0] adc14, lim14, low_c, top_c, c14;
    logic signed [13:0] prev14, cc14, up14, dn14, f14;
    logic [22:0]        yprod;

    hold_phase_t phase_next;
    logic [15:0] hold_count_next;
    logic [7:0]  jitter_next;
    logic [7:0]  window_start_next;
    logic [7:0]  window_stop_next;
    logic [7:0]  sweep_pos_next;
    logic        sweep_rising_next;

    assign s_val = $signed({1'b0, adc_reg}) - $signed({1'b0, dc_offset_reg});

    always_comb
    begin
        mul_a = K_BASS_IN;
        mul_b = {{11{s_val[12]}}, s_val};
        case (cmd.src)
            SRC_XB: begin mul_a = K_BASS_IN; mul_b = {{11{s_val[12]}}, s_val}; end
            SRC_BA: begin mul_a = ext48(bass_hist_reg[2]); mul_b = C_BASS_A; end
            SRC_BB: begin mul_a = ext48(bass_hist_reg[3]); mul_b = C_BASS_B; end
            SRC_EV: begin mul_a = acc_reg; mul_b = K_ENV_IN; end
            SRC_EF: begin mul_a = ext48(env_hist_reg[1]); mul_b = C_ENV; end
            SRC_KB: begin mul_a = acc_reg; mul_b = K_BEAT_IN; end
            SRC_TA: begin mul_a = ext48(beatf_hist_reg[2]); mul_b = C_BEAT_A; end
            SRC_TB: begin mul_a = ext48(beatf_hist_reg[3]); mul_b = C_BEAT_B; end
            SRC_JR: begin mul_a = sum_reg; mul_b = $signed({14'd0, beat_ratio_reg}); end
            SRC_JD: begin mul_a = acc_reg; mul_b = 24'(HISTORY_DEPTH); end
            default: begin mul_a = acc_reg; mul_b = 24'sd0; end
        endcase
    end

    // The low half of the operand is unsigned, the high half carries the sign.
    assign plo_next  = $signed({1'b0, mul_a[23:0]}) * mul_b;
    assign phi       = $signed(mul_a[47:24]) * mul_b;
    assign prod_next = $signed({phi, 24'd0}) + {{23{plo_reg[48]}}, plo_reg};
    assign rnd       = round22(prod_reg);
    assign rnd_sat   = sat40({rnd[49], rnd});
    assign acc_sat   = sat40(ext51(acc_reg) + {rnd[49], rnd});

    // Clamp and slew limit.
    always_comb
    begin
        adc14  = $signed({2'd0, adc_reg});
        lim14  = $signed({4'd0, slew_limit_reg});
        top_c  = $signed(CLAMP_TOP) - lim14;
        low_c  = (adc14 < lim14 + 14'sd1) ? lim14 : adc14;
        c14    = (low_c > top_c) ? top_c : low_c;
        prev14 = $signed({2'd0, slew_prev_reg});
        cc14   = $signed({2'd0, c_reg});
        up14   = prev14 + lim14;
        dn14   = prev14 - lim14;
        if (cc14 > up14)
            f14 = up14;
        else if (cc14 < dn14)
            f14 = dn14;
        else
            f14 = cc14;
    end

    assign yprod = slew_prev_reg * Y_RECIP;

    // Hold machine and sweep for the finishing step.
    always_comb
    begin
        phase_next        = phase_reg;
        hold_count_next   = hold_count_reg;
        jitter_next       = jitter_reg;
        window_start_next = window_start_reg;
        window_stop_next  = window_stop_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (hold_count_reg != 16'd0)
                    hold_count_next = hold_count_reg - 16'd1;
                else if (beat_reg)
                begin
                    hold_count_next = blank_ticks_reg;
                    phase_next      = PH_BLANK1;
                end
            end
            PH_BLANK1:
            begin
                jitter_next       = {2'd0, jdraw_reg} - JITTER_BIAS;
                window_start_next = {1'b0, sdraw_reg};
                window_stop_next  = sweep_max_reg - {1'b0, pdraw_reg};
                if (hold_count_reg != 16'd0)
                    hold_count_next = hold_count_reg - 16'd1;
                else
                begin
                    hold_count_next = active_ticks_reg;
                    phase_next      = PH_ACTIVE;
                end
            end
            PH_ACTIVE:
            begin
                if (hold_count_reg != 16'd0)
                    hold_count_next = hold_count_reg - 16'd1;
                else
                begin
                    hold_count_next = blank_ticks_reg;
                    phase_next      = PH_BLANK2;
                end
            end
            PH_BLANK2:
            begin
                if (hold_count_reg != 16'd0)
                    hold_count_next = hold_count_reg - 16'd1;
                else
                begin
                    hold_count_next = rearm_ticks_reg;
                    phase_next      = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase

        if (sweep_rising_reg)
        begin
            sweep_pos_next    = sweep_pos_reg + 8'd1;
            sweep_rising_next = (sweep_pos_next != sweep_max_reg);
        end
        else
        begin
            sweep_pos_next    = sweep_pos_reg - 8'd1;
            sweep_rising_next = (sweep_pos_next == 8'd0);
        end
    end

    assign status.decim_hit = (decim_count_reg == 8'(DECIMATION));
    assign status.sum_last  = (idx_reg == IDX_W'(HISTORY_DEPTH - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.mul_lo)
            plo_reg <= plo_next;
        if (cmd.mul_hi)
            prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slew_limit_reg   <= RST_SLEW_LIMIT;
            sweep_max_reg    <= RST_SWEEP_MAX;
            dc_offset_reg    <= RST_DC_OFFSET;
            beat_ratio_reg   <= RST_BEAT_RATIO;
            beat_margin_reg  <= RST_BEAT_MARGIN;
            blank_ticks_reg  <= RST_BLANK_TICKS;
            active_ticks_reg <= RST_ACTIVE_TICKS;
            rearm_ticks_reg  <= RST_REARM_TICKS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SLEW_LIMIT:   slew_limit_reg   <= cfg_data[9:0];
                REG_SWEEP_MAX:    sweep_max_reg    <= cfg_data[7:0];
                REG_DC_OFFSET:    dc_offset_reg    <= cfg_data[11:0];
                REG_BEAT_RATIO:   beat_ratio_reg   <= cfg_data[9:0];
                REG_BEAT_MARGIN:  beat_margin_reg  <= cfg_data[9:0];
                REG_BLANK_TICKS:  blank_ticks_reg  <= cfg_data;
                REG_ACTIVE_TICKS: active_ticks_reg <= cfg_data;
                REG_REARM_TICKS:  rearm_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.post)
            P_CAPTURE:
            begin
                adc_reg   <= adc_sample;
                jdraw_reg <= jitter_draw;
                sdraw_reg <= start_draw;
                pdraw_reg <= stop_draw;
            end
            P_XB:
            begin
                xin_reg <= rnd_sat;
                acc_reg <= ext48(rnd_sat) - ext48(bass_hist_reg[0]);
                c_reg   <= c14[11:0];
            end
            P_ACC:    acc_reg <= acc_reg + rnd[47:0];
            P_BASS_Y: acc_reg <= ext48(acc_sat);
            P_ABS:
            begin
                if (acc_reg[39:0] == MIN40[39:0])
                    acc_reg <= ext48(MAX40[39:0]);
                else if (acc_reg[47])
                    acc_reg <= -acc_reg;
            end
            P_ENV_XE:
            begin
                xin_reg  <= rnd_sat;
                acc_reg  <= ext48(env_hist_reg[0]) + ext48(rnd_sat);
                ydiv_reg <= yprod[Y_SHIFT+6:Y_SHIFT];
            end
            P_ENV_E:  acc_reg <= ext48(acc_sat);
            P_BEAT_X:
            begin
                xin_reg <= rnd_sat;
                acc_reg <= ext48(rnd_sat) - ext48(beatf_hist_reg[0]);
            end
            P_BEAT_Y:
            begin
                val_reg <= acc_sat;
                sum_reg <= 48'sd0;
                idx_reg <= '0;
            end
            P_SUM:
            begin
                sum_reg <= sum_reg + ext48(judge_window_reg[idx_reg]);
                idx_reg <= idx_reg + IDX_W'(1);
            end
            P_JR:
            begin
                lhs_reg <= prod_reg[63:0];
                acc_reg <= ext48(val_reg) - $signed(48'(beat_margin_reg) << FRAC_BITS);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                bass_hist_reg[i]  <= '0;
                beatf_hist_reg[i] <= '0;
            end
            env_hist_reg[0] <= '0;
            env_hist_reg[1] <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                judge_window_reg[i] <= '0;
            decim_count_reg  <= '0;
            beat_reg         <= 1'b0;
            slew_prev_reg    <= RST_SLEW_PREV;
            sweep_pos_reg    <= '0;
            sweep_rising_reg <= 1'b1;
            phase_reg        <= PH_IDLE;
            hold_count_reg   <= '0;
            jitter_reg       <= '0;
            window_start_reg <= '0;
            window_stop_reg  <= RST_WINDOW_STOP;
            dac_x_reg        <= '0;
            dac_y_reg        <= '0;
            beam_on_reg      <= 1'b0;
            beat_seen_reg    <= 1'b0;
            beat_phase_reg   <= '0;
        end
        else
        begin
            case (cmd.post)
                P_CAPTURE: beat_reg <= 1'b0;
                P_BASS_Y:
                begin
                    bass_hist_reg[0] <= bass_hist_reg[1];
                    bass_hist_reg[1] <= xin_reg;
                    bass_hist_reg[2] <= bass_hist_reg[3];
                    bass_hist_reg[3] <= acc_sat;
                end
                P_ABS: slew_prev_reg <= f14[11:0];
                P_ENV_E:
                begin
                    env_hist_reg[0] <= xin_reg;
                    env_hist_reg[1] <= acc_sat;
                    if (status.decim_hit)
                        decim_count_reg <= '0;
                    else
                        decim_count_reg <= decim_count_reg + 8'd1;
                end
                P_BEAT_Y:
                begin
                    beatf_hist_reg[0] <= beatf_hist_reg[1];
                    beatf_hist_reg[1] <= xin_reg;
                    beatf_hist_reg[2] <= beatf_hist_reg[3];
                    beatf_hist_reg[3] <= acc_sat;
                end
                P_JD:
                begin
                    // Both sides of the beat decision are signed.
                    beat_reg <= (lhs_reg < $signed(prod_reg[63:0]));
                    for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                        judge_window_reg[i] <= judge_window_reg[i + 1];
                    judge_window_reg[HISTORY_DEPTH - 1] <= val_reg;
                end
                P_FINISH:
                begin
                    phase_reg        <= phase_next;
                    hold_count_reg   <= hold_count_next;
                    jitter_reg       <= jitter_next;
                    window_start_reg <= window_start_next;
                    window_stop_reg  <= window_stop_next;
                    sweep_pos_reg    <= sweep_pos_next;
                    sweep_rising_reg <= sweep_rising_next;
                    dac_x_reg        <= sweep_pos_next;
                    dac_y_reg        <= {1'b0, ydiv_reg} + jitter_next;
                    beam_on_reg      <= (sweep_pos_next >= window_start_next) &&
                                        (sweep_pos_next <= window_stop_next);
                    beat_seen_reg    <= beat_reg;
                    beat_phase_reg   <= phase_next;
                end
                default: ;
            endcase
        end
    end

    assign dac_x      = dac_x_reg;
    assign dac_y      = dac_y_reg;
    assign beam_on    = beam_on_reg;
    assign beat_seen  = beat_seen_reg;
    assign beat_phase = beat_phase_reg;

endmodule

[src/beat_reactive_scope_sweep_unit.sv]
// ----------------------------------------------------------------------------
// beat_reactive_scope_sweep_unit
// Audio beat detector driving an x/y beam sweep, one result beat per sample.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one sample tick per beat:
//   adc_sample and three pre-reduced random draws. The unit takes a beat
//   only when idle; in_stall is high while a tick is being worked on.
//   Output channel (out_valid / out_stall) delivers dac_x, dac_y, beam_on,
//   beat_seen and beat_phase. The result sits in an output register; while
//   out_stall is high it holds, and the unit still accepts and processes the
//   next tick, waiting only at its final step for the register to free.
//   A decimation tick takes longer than an ordinary tick, since it also runs
//   the beat filter, the history sum and the beat decision; a new tick can
//   be accepted once the unit is back in idle. The duration follows from
//   the single shared multiplier, which forms each product as a low and a
//   high half, and from the history sum, which reads one entry a cycle.
//   The cfg port (cfg_valid / cfg_ready, always ready) writes registers
//   0..7; the user must write them only while the unit is idle, as the unit
//   itself does not enforce it. Reset restores the configuration registers
//   and the filter state to their defaults at once.
// ----------------------------------------------------------------------------
module beat_reactive_scope_sweep_unit
    import bss_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10,
    parameter int DECIMATION    = 200,
    parameter int FRAC_BITS     = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] adc_sample,
    input  logic [5:0]  jitter_draw,
    input  logic [6:0]  start_draw,
    input  logic [6:0]  stop_draw,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  dac_x,
    output logic [7:0]  dac_y,
    output logic        beam_on,
    output logic        beat_seen,
    output logic [1:0]  beat_phase,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    bss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bss_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .DECIMATION    (DECIMATION),
        .FRAC_BITS     (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .adc_sample  (adc_sample),
        .jitter_draw (jitter_draw),
        .start_draw  (start_draw),
        .stop_draw   (stop_draw),
        .dac_x       (dac_x),
        .dac_y       (dac_y),
        .beam_on     (beam_on),
        .beat_seen   (beat_seen),
        .beat_phase  (beat_phase)
    );

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench of beat_reactive_scope_sweep_unit. Sample ticks are sent as
// beats in random bursts while the result side stalls on its own pattern.
// A fixed-point predictor of the filter chain, the hold machine, the slew
// limiter and the sweep computes every result, and each result beat is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import bss_pkg::*;

    localparam int  HIST_LEN   = 10;
    localparam int  DECIM      = 200;
    localparam int  FRAC       = 16;
    localparam longint LIM_HI  = 64'sd549755813887;
    localparam longint LIM_LO  = -64'sd549755813888;
    localparam longint K_BASS  = ((64'sd1 <<< (FRAC + 22)) * 10 + 45) / 91;
    localparam longint K_ENV   = ((64'sd1 <<< 22) + 80) / 160;
    localparam longint K_BEAT  = ((64'sd1 <<< 22) * 1000 + 3507) / 7015;

    typedef struct {
        logic [7:0]  x;
        logic [7:0]  y;
        logic        beam;
        logic        beat;
        hold_phase_t ph;
    } scope_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [11:0] adc_sample = '0;
    logic [5:0]  jitter_draw = '0;
    logic [6:0]  start_draw = '0;
    logic [6:0]  stop_draw = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  dac_x;
    logic [7:0]  dac_y;
    logic        beam_on;
    logic        beat_seen;
    logic [1:0]  beat_phase;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    beat_reactive_scope_sweep_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_sample (adc_sample),
        .jitter_draw(jitter_draw),
        .start_draw (start_draw),
        .stop_draw  (stop_draw),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .dac_x      (dac_x),
        .dac_y      (dac_y),
        .beam_on    (beam_on),
        .beat_seen  (beat_seen),
        .beat_phase (beat_phase),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // Register copies.
    logic [9:0]  m_slew_limit, m_beat_ratio, m_beat_margin;
    logic [7:0]  m_sweep_max;
    logic [11:0] m_dc_offset;
    logic [15:0] m_blank_ticks, m_active_ticks, m_rearm_ticks;

    // Scope state copies.
    logic [7:0]  m_x_pos;
    logic        m_x_rising;
    logic [11:0] m_slewed;
    logic [7:0]  m_decim;
    longint      m_bass[4];
    longint      m_env[2];
    longint      m_beatf[4];
    longint      m_hist[HIST_LEN];
    hold_phase_t m_phase;
    logic [15:0] m_hold;
    logic [7:0]  m_jitter, m_win_start, m_win_stop;

    scope_result_t pending_results[$];
    int mismatches = 0;
    int burst_left = 0;

    function automatic longint clip40(longint v);
        if (v > LIM_HI)
            return LIM_HI;
        if (v < LIM_LO)
            return LIM_LO;
        return v;
    endfunction

    function automatic longint qmul(longint v, longint c);
        longint p;
        p = v * c + 64'sd2097152;
        return p >>> 22;
    endfunction

    task automatic bp_filter(ref longint h[4], input longint xin, input longint ca,
                             input longint cb, output longint y);
        y = clip40((xin - h[0]) + qmul(h[2], ca) + qmul(h[3], cb));
        h[0] = h[1];
        h[1] = xin;
        h[2] = h[3];
        h[3] = y;
    endtask

    task automatic scope_reset();
        m_slew_limit = 10'd130;  m_sweep_max = 8'd222;  m_dc_offset = 12'd1430;
        m_beat_ratio = 10'd145;  m_beat_margin = 10'd45;
        m_blank_ticks = 16'd3;   m_active_ticks = 16'd100; m_rearm_ticks = 16'd2000;
        m_x_pos = '0; m_x_rising = 1'b1; m_slewed = 12'd2048; m_decim = '0;
        m_bass = '{default: 0}; m_env = '{default: 0};
        m_beatf = '{default: 0}; m_hist = '{default: 0};
        m_phase = PH_IDLE; m_hold = '0; m_jitter = '0; m_win_start = '0;
        m_win_stop = 8'd222;
    endtask

    task automatic scope_tick(input logic [11:0] adc, input logic [5:0] jd,
                              input logic [6:0] sd, input logic [6:0] pd);
        longint s, v, xe, e, bv, total;
        int lim, c, f;
        logic hit;
        scope_result_t r;
        hit = 1'b0;
        s = longint'(adc) - longint'(m_dc_offset);
        bp_filter(m_bass, clip40(qmul(s, K_BASS)), longint'(C_BASS_A),
                  longint'(C_BASS_B), v);
        if (v < 0)
            v = (v == LIM_LO) ? LIM_HI : -v;
        xe = clip40(qmul(v, K_ENV));
        e = clip40(m_env[0] + xe + qmul(m_env[1], longint'(C_ENV)));
        m_env[0] = xe;
        m_env[1] = e;

        if (m_decim == 8'(DECIM)) begin
            m_decim = '0;
            bp_filter(m_beatf, clip40(qmul(e, K_BEAT)), longint'(C_BEAT_A),
                      longint'(C_BEAT_B), bv);
            total = 0;
            for (int i = 0; i < HIST_LEN; i++)
                total += m_hist[i];
            for (int i = 0; i < HIST_LEN - 1; i++)
                m_hist[i] = m_hist[i + 1];
            m_hist[HIST_LEN - 1] = bv;
            hit = (total * longint'(m_beat_ratio)) <
                  longint'(HIST_LEN) * (bv - (longint'(m_beat_margin) <<< FRAC));
        end else begin
            m_decim = m_decim + 8'd1;
        end

        case (m_phase)
            PH_IDLE: begin
                if (m_hold != 0)
                    m_hold--;
                else if (hit) begin
                    m_hold = m_blank_ticks;
                    m_phase = PH_BLANK1;
                end
            end
            PH_BLANK1: begin
                m_jitter = 8'(jd) - 8'd25;
                m_win_start = 8'(sd);
                m_win_stop = m_sweep_max - 8'(pd);
                if (m_hold != 0)
                    m_hold--;
                else begin
                    m_hold = m_active_ticks;
                    m_phase = PH_ACTIVE;
                end
            end
            PH_ACTIVE: begin
                if (m_hold != 0)
                    m_hold--;
                else begin
                    m_hold = m_blank_ticks;
                    m_phase = PH_BLANK2;
                end
            end
            default: begin
                if (m_hold != 0)
                    m_hold--;
                else begin
                    m_hold = m_rearm_ticks;
                    m_phase = PH_IDLE;
                end
            end
        endcase

        lim = int'(m_slew_limit);
        c = int'(adc);
        if (c < lim + 1)
            c = lim;
        if (c > 4090 - lim)
            c = 4090 - lim;
        if (c > int'(m_slewed) + lim)
            f = int'(m_slewed) + lim;
        else if (c < int'(m_slewed) - lim)
            f = int'(m_slewed) - lim;
        else
            f = c;
        m_slewed = 12'(f);

        if (m_x_rising) begin
            m_x_pos = m_x_pos + 8'd1;
            if (m_x_pos == m_sweep_max)
                m_x_rising = 1'b0;
        end else begin
            m_x_pos = m_x_pos - 8'd1;
            if (m_x_pos == 8'd0)
                m_x_rising = 1'b1;
        end

        r.x = m_x_pos;
        r.y = 8'(m_slewed / 12'd50) + m_jitter;
        r.beam = (m_x_pos >= m_win_start) && (m_x_pos <= m_win_stop);
        r.beat = hit;
        r.ph = m_phase;
        pending_results.push_back(r);
    endtask

    // Sends one sample tick and predicts its result once it is taken.
    task automatic send_tick(input logic [11:0] adc, input logic [5:0] jd,
                             input logic [6:0] sd, input logic [6:0] pd);
        in_valid <= 1'b1;
        adc_sample <= adc;
        jitter_draw <= jd;
        start_draw <= sd;
        stop_draw <= pd;
        do
            @(posedge clk);
        while (in_stall);
        scope_tick(adc, jd, sd, pd);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_random_tick();
        send_tick(12'($urandom), 6'($urandom), 7'($urandom), 7'($urandom));
    endtask

    // Lowers the input valid and waits until the unit has gone idle.
    task automatic drain_unit();
        int waited;
        @(posedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SLEW_LIMIT:   m_slew_limit = value[9:0];
            REG_SWEEP_MAX:    m_sweep_max = value[7:0];
            REG_DC_OFFSET:    m_dc_offset = value[11:0];
            REG_BEAT_RATIO:   m_beat_ratio = value[9:0];
            REG_BEAT_MARGIN:  m_beat_margin = value[9:0];
            REG_BLANK_TICKS:  m_blank_ticks = value;
            REG_ACTIVE_TICKS: m_active_ticks = value;
            default:          m_rearm_ticks = value;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] slew, input logic [15:0] sweep,
                                 input logic [15:0] dc, input logic [15:0] ratio,
                                 input logic [15:0] margin, input logic [15:0] blank,
                                 input logic [15:0] active, input logic [15:0] rearm);
        drain_unit();
        write_reg(REG_SLEW_LIMIT, slew);
        write_reg(REG_SWEEP_MAX, sweep);
        write_reg(REG_DC_OFFSET, dc);
        write_reg(REG_BEAT_RATIO, ratio);
        write_reg(REG_BEAT_MARGIN, margin);
        write_reg(REG_BLANK_TICKS, blank);
        write_reg(REG_ACTIVE_TICKS, active);
        write_reg(REG_REARM_TICKS, rearm);
    endtask

    // Mostly bass-heavy tones with bursts of loudness, so that the envelope
    // swings and the beat decision fires; the rest is plain noise.
    task automatic send_music(input int count);
        int period, amp, pos, level;
        period = 8;
        amp = 0;
        pos = 0;
        for (int n = 0; n < count; n++) begin
            if (pos == 0 && $urandom_range(0, 3) == 0) begin
                period = $urandom_range(4, 80);
                amp = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 100)
                                                  : $urandom_range(500, 2047);
            end
            pos = (pos + 1) % period;
            if ($urandom_range(0, 4) == 0) begin
                send_random_tick();
            end else begin
                level = 2048 + ((pos < period / 2) ? amp : -amp)
                        + $urandom_range(0, 64) - 32;
                if (level < 0)
                    level = 0;
                if (level > 4095)
                    level = 4095;
                send_tick(12'(level), 6'($urandom_range(0, 49)),
                          7'($urandom_range(0, 99)), 7'($urandom_range(0, 99)));
            end
        end
    endtask

    task automatic test_field_extremes();
        send_tick(12'd0, 6'd0, 7'd0, 7'd0);
        send_tick(12'd4095, 6'd63, 7'd127, 7'd127);
        send_tick(12'd0, 6'd49, 7'd99, 7'd99);
        send_tick(12'd4095, 6'd25, 7'd50, 7'd0);
        send_tick(12'd130, 6'd0, 7'd127, 7'd0);
        send_tick(12'd131, 6'd63, 7'd0, 7'd127);
        send_tick(12'd3960, 6'd1, 7'd1, 7'd1);
        send_tick(12'd3961, 6'd62, 7'd126, 7'd126);
        send_tick(12'd2048, 6'd32, 7'd64, 7'd64);
        send_tick(12'd1430, 6'd31, 7'd63, 7'd63);
        for (int i = 0; i < 10; i++)
            send_tick(i[0] ? 12'd4095 : 12'd0, 6'd0, 7'd0, 7'd0);
        send_music(200);
    endtask

    // Zero hold counts and a zero sweep turning point: the hold phases advance
    // every tick once a beat starts them, and x runs the whole 8-bit range.
    task automatic test_zero_holds_full_sweep();
        load_settings(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_music(220);
    endtask

    task automatic test_register_maxima();
        load_settings(16'd1023, 16'd255, 16'd4095, 16'd1023, 16'd1023,
                      16'd65535, 16'd65535, 16'd65535);
        send_music(150);
    endtask

    // A sweep turning point of one after a wide sweep leaves x above it,
    // so a rising x wraps before it turns. Short holds let several beats through.
    task automatic test_short_holds_narrow_sweep();
        load_settings(16'd37, 16'd1, 16'd2048, 16'd1, 16'd0, 16'd2, 16'd5, 16'd3);
        send_music(300);
    endtask

    task automatic test_random_settings();
        for (int k = 0; k < 5; k++) begin
            load_settings(16'($urandom_range(1, 1023)), 16'($urandom_range(1, 255)),
                          16'($urandom_range(0, 4095)), 16'($urandom_range(0, 300)),
                          16'($urandom_range(0, 200)), 16'($urandom_range(0, 6)),
                          16'($urandom_range(0, 40)), 16'($urandom_range(0, 30)));
            send_music(50);
        end
    endtask

    // Result side stall pattern; the stall rate changes now and then.
    int stall_pct = 0;
    always @(posedge clk) begin
        if ($urandom_range(0, 199) == 0)
            stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 85);
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        scope_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no prediction waiting");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (dac_x !== want.x) begin
                    $error("dac_x: expected %0d, got %0d", want.x, dac_x);
                    mismatches++;
                end
                if (dac_y !== want.y) begin
                    $error("dac_y: expected %0d, got %0d", want.y, dac_y);
                    mismatches++;
                end
                if (beam_on !== want.beam) begin
                    $error("beam_on: expected %0d, got %0d", want.beam, beam_on);
                    mismatches++;
                end
                if (beat_seen !== want.beat) begin
                    $error("beat_seen: expected %0d, got %0d", want.beat, beat_seen);
                    mismatches++;
                end
                if (beat_phase !== want.ph) begin
                    $error("beat_phase: expected %0d, got %0d", want.ph, beat_phase);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        scope_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_zero_holds_full_sweep();
        test_register_maxima();
        test_short_holds_narrow_sweep();
        test_random_settings();
        drain_unit();
        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("** beat_reactive_scope_sweep_unit: PASSED **");
        else
            $display("** beat_reactive_scope_sweep_unit: FAILED **");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("** beat_reactive_scope_sweep_unit: FAILED **");
        $finish;
    end

endmodule
